@@ sv/fraction_reducer_gcd_unit_macros.svh @@
// Assertion macros for the fraction reducer controller.
`ifndef FRACTION_REDUCER_GCD_UNIT_MACROS_SVH
`define FRACTION_REDUCER_GCD_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define FRG_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frg assertion failed");
// Next-cycle implication, disabled during reset.
`define FRG_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frg assertion failed");
`else
`define FRG_ASSERT_IMP(label, clk, rst, ante, cons)
`define FRG_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

@@ sv/frg_pkg.sv @@
// Types and constants shared by the fraction reducer modules.
package frg_pkg;

  localparam int VALUE_WIDTH = 14;
  localparam int CNT_W       = $clog2(VALUE_WIDTH);

  typedef logic [VALUE_WIDTH-1:0] value_t;
  typedef logic [CNT_W-1:0]       cnt_t;

  localparam value_t MAX_VALUE_RESET = VALUE_WIDTH'(10000);
  localparam cnt_t   DIV_LAST        = CNT_W'(VALUE_WIDTH - 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_GCD  = 4'b0010,
    S_DIV  = 4'b0100,
    S_HOLD = 4'b1000
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic gcd_step;
    logic div_step;
    logic out_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic err;
    logic gcd_done;
  } status_t;

endpackage

@@ sv/fraction_reducer_gcd_unit.sv @@
// Fraction reducer top level: reduces numerator/denominator to lowest terms.
//
// Input channel: in_valid/in_ready with numerator and denominator; a
// transaction completes when both are high. Output channel: out_valid/out_ready
// with reduced_numerator, reduced_denominator and input_error.
// cfg_we/cfg_wdata write max_value (reset value 10000).
// A zero input, or one above max_value, gives input_error = 1 and zero results.
// After acceptance the block runs binary GCD steps until x == y (each step
// drops at least one bit from the pair, so there are at most 26), then the
// two restoring dividers side by side, then loads the output register.
// An error item skips GCD and division and goes to the output register.
// One item is in work at a time; in_ready is high only while idle and comes
// back the cycle after the output register loads.
// The output register decouples the sides: the next item is taken and
// processed while a result waits, and it holds in the last state until the
// receiver takes the waiting result.
// Reset (rst, synchronous) empties the block and restores max_value.
module fraction_reducer_gcd_unit
  import frg_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   cfg_we,
  input  value_t cfg_wdata,
  input  logic   in_valid,
  output logic   in_ready,
  input  value_t numerator,
  input  value_t denominator,
  output logic   out_valid,
  input  logic   out_ready,
  output value_t reduced_numerator,
  output value_t reduced_denominator,
  output logic   input_error
);

  cmd_t    cmd;
  status_t status;

  frg_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  frg_datapath u_dp (
    .clk                 (clk),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .rst                 (rst),
    .numerator           (numerator),
    .denominator         (denominator),
    .cmd                 (cmd),
    .status              (status),
    .reduced_numerator   (reduced_numerator),
    .reduced_denominator (reduced_denominator),
    .input_error         (input_error)
  );

endmodule

@@ sv/frg_datapath.sv @@
// Datapath: limit register, binary GCD, two restoring dividers, result register.
module frg_datapath
  import frg_pkg::*;
(
  input  logic    clk,
  input  logic    cfg_we,
  input  value_t  cfg_wdata,
  input  logic    rst,
  input  value_t  numerator,
  input  value_t  denominator,
  input  cmd_t    cmd,
  output status_t status,
  output value_t  reduced_numerator,
  output value_t  reduced_denominator,
  output logic    input_error
);

  value_t max_value;
  value_t x, y;          // gcd working pair
  value_t n, d;          // dividends, later quotients
  value_t rem_n, rem_d;
  logic   err;

  value_t x_next, y_next, n_next, d_next;
  value_t rem_n_next, rem_d_next;
  logic   bad;

  function automatic logic [2*VALUE_WIDTH-1:0] div_step_f(value_t rem, value_t dv,
                                                          value_t dvs);
    logic [VALUE_WIDTH:0] t;
    logic                 qbit;
    value_t               rem_o;
    t     = {rem, dv[VALUE_WIDTH-1]};
    qbit  = (t >= {1'b0, dvs});
    rem_o = qbit ? VALUE_WIDTH'(t - {1'b0, dvs}) : t[VALUE_WIDTH-1:0];
    return {rem_o, dv[VALUE_WIDTH-2:0], qbit};
  endfunction

  assign bad = (numerator == '0) || (denominator == '0) ||
               (numerator > max_value) || (denominator > max_value);

  assign status.err      = err;
  assign status.gcd_done = (x == y);

  always_comb begin
    x_next     = x;
    y_next     = y;
    n_next     = n;
    d_next     = d;
    rem_n_next = rem_n;
    rem_d_next = rem_d;
    if (cmd.gcd_step) begin
      // both even: common factor of two comes out of the dividends too
      if (!x[0] && !y[0]) begin
        x_next = x >> 1;
        y_next = y >> 1;
        n_next = n >> 1;
        d_next = d >> 1;
      end else if (!x[0]) begin
        x_next = x >> 1;
      end else if (!y[0]) begin
        y_next = y >> 1;
      end else if (x > y) begin
        x_next = (x - y) >> 1;
      end else begin
        y_next = (y - x) >> 1;
      end
    end else if (cmd.div_step) begin
      {rem_n_next, n_next} = div_step_f(rem_n, n, x);
      {rem_d_next, d_next} = div_step_f(rem_d, d, x);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_value <= MAX_VALUE_RESET;
    end else if (cfg_we) begin
      max_value <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x     <= numerator;
      y     <= denominator;
      n     <= numerator;
      d     <= denominator;
      rem_n <= '0;
      rem_d <= '0;
      err   <= bad;
    end else begin
      x     <= x_next;
      y     <= y_next;
      n     <= n_next;
      d     <= d_next;
      rem_n <= rem_n_next;
      rem_d <= rem_d_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      reduced_numerator   <= err ? '0 : n;
      reduced_denominator <= err ? '0 : d;
      input_error         <= err;
    end
  end

endmodule

@@ sv/frg_controller.sv @@
// Controller: sequences load, GCD, division and result hand-off.
`include "fraction_reducer_gcd_unit_macros.svh"
module frg_controller
  import frg_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;
  cnt_t   cnt, cnt_next;
  logic   out_valid_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_GCD;
        end
      end
      S_GCD: begin
        cnt_next = '0;
        if (status.err) begin
          state_next = S_HOLD;
        end else if (status.gcd_done) begin
          state_next = S_DIV;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + cnt_t'(1);
        if (cnt == DIV_LAST) begin
          state_next = S_HOLD;
        end
      end
      S_HOLD: begin
        // wait for the result register to free up
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  `FRG_ASSERT_NXT(a_accept_to_gcd, clk, rst, in_valid && in_ready, state == S_GCD)
  `FRG_ASSERT_NXT(a_gcd_to_div, clk, rst,
                  (state == S_GCD) && status.gcd_done && !status.err, state == S_DIV)
  `FRG_ASSERT_NXT(a_div_to_hold, clk, rst, (state == S_DIV) && (cnt == DIV_LAST), state == S_HOLD)
  `FRG_ASSERT_IMP(a_no_overwrite, clk, rst, cmd.out_load && out_valid, out_ready)

endmodule

@@ bench/testbench.sv @@
// Self-checking testbench for fraction_reducer_gcd_unit: limit register, reduction, error flag.
module testbench;
  import frg_pkg::*;

  localparam int QUIET_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 60;
  localparam int HOLD_CYCLES  = 400;
  localparam int VALUE_TOP    = (1 << VALUE_WIDTH) - 1;

  typedef struct packed {
    value_t num;
    value_t den;
    logic   err;
  } reduced_t;

  // Tracks the limit register and the queue of reduced fractions still owed.
  class fraction_scoreboard;
    value_t   limit;
    reduced_t pending[$];
    int       mismatches;
    int       fractions_taken;
    int       results_seen;
    int       errors_flagged;

    function new();
      limit           = MAX_VALUE_RESET;
      mismatches      = 0;
      fractions_taken = 0;
      results_seen    = 0;
      errors_flagged  = 0;
    endfunction

    function void set_limit(value_t v);
      limit = v;
    endfunction

    function int unsigned common_divisor(int unsigned a, int unsigned b);
      int unsigned r;
      while (b != 0) begin
        r = a % b;
        a = b;
        b = r;
      end
      return a;
    endfunction

    function void note_fraction(value_t n, value_t d);
      reduced_t    want;
      int unsigned g;
      fractions_taken++;
      if (n == 0 || d == 0 || n > limit || d > limit) begin
        want.num = '0;
        want.den = '0;
        want.err = 1'b1;
      end else begin
        g        = common_divisor(n, d);
        want.num = value_t'(int'(n) / g);
        want.den = value_t'(int'(d) / g);
        want.err = 1'b0;
      end
      pending.push_back(want);
    endfunction

    function void check_result(value_t rn, value_t rd, logic err);
      reduced_t want;
      results_seen++;
      if (err === 1'b1) errors_flagged++;
      if (pending.size() == 0) begin
        $display("%0t: result with nothing outstanding: num %0d den %0d err %0b",
                 $time, rn, rd, err);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      if (rn !== want.num) begin
        $display("%0t: reduced_numerator expected %0d actual %0d", $time, want.num, rn);
        mismatches++;
      end
      if (rd !== want.den) begin
        $display("%0t: reduced_denominator expected %0d actual %0d", $time, want.den, rd);
        mismatches++;
      end
      if (err !== want.err) begin
        $display("%0t: input_error expected %0b actual %0b", $time, want.err, err);
        mismatches++;
      end
    endfunction
  endclass

  logic   clk;
  logic   rst;
  logic   cfg_we;
  value_t cfg_wdata;
  logic   in_valid;
  logic   in_ready;
  value_t numerator;
  value_t denominator;
  logic   out_valid;
  logic   out_ready;
  value_t reduced_numerator;
  value_t reduced_denominator;
  logic   input_error;

  fraction_scoreboard sb;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_left;
  int quiet_cycles;
  int limit_writes;

  fraction_reducer_gcd_unit i_dut (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .numerator           (numerator),
    .denominator         (denominator),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .reduced_numerator   (reduced_numerator),
    .reduced_denominator (reduced_denominator),
    .input_error         (input_error)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: random backpressure, plus a long hold-off when requested.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        out_ready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Both channels observed at the rising edge.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (in_valid && in_ready) sb.note_fraction(numerator, denominator);
      if (out_valid && out_ready)
        sb.check_result(reduced_numerator, reduced_denominator, input_error);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("%0t: no transaction for %0d cycles, %0d results outstanding",
             $time, QUIET_LIMIT, sb.pending.size());
    $display("testbench NOT OK");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_fraction(value_t n, value_t d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid    = 1'b1;
    numerator   = n;
    denominator = d;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // Only called with the block idle.
  task automatic write_limit(value_t v);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_limit(v);
    limit_writes++;
  endtask

  function automatic value_t pick_value(int unsigned top, int unsigned g);
    int unsigned v;
    case ($urandom_range(3))
      0: v = 1;
      1: v = top;
      default: v = $urandom_range(1, top);
    endcase
    return value_t'(v * g);
  endfunction

  task automatic send_random(int count);
    int unsigned lim;
    int unsigned g;
    int unsigned top;
    int unsigned sel;
    value_t      n;
    value_t      d;
    for (int i = 0; i < count; i++) begin
      lim = sb.limit;
      sel = $urandom_range(99);
      if (lim == 0 || sel >= 85) begin
        // anything the port allows, including zero and out-of-limit values
        n = value_t'($urandom_range(0, VALUE_TOP));
        d = value_t'($urandom_range(0, VALUE_TOP));
      end else if (sel < 60) begin
        // in range with a shared factor
        g   = ($urandom_range(1)) ? $urandom_range(1, (lim < 16) ? lim : 16)
                                  : $urandom_range(1, lim);
        top = lim / g;
        n   = pick_value(top, g);
        d   = pick_value(top, g);
      end else if (sel < 72) begin
        n = value_t'($urandom_range(1, lim));
        d = value_t'($urandom_range(1, lim));
      end else begin
        // around the limit and zero
        case ($urandom_range(3))
          0: n = '0;
          1: n = value_t'(lim);
          2: n = value_t'((lim < VALUE_TOP) ? lim + 1 : lim);
          default: n = value_t'($urandom_range(1, lim));
        endcase
        case ($urandom_range(3))
          0: d = '0;
          1: d = value_t'(lim);
          2: d = value_t'((lim < VALUE_TOP) ? lim + 1 : lim);
          default: d = value_t'($urandom_range(1, lim));
        endcase
      end
      send_fraction(n, d);
    end
  endtask

  initial begin
    sb            = new();
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    in_valid      = 1'b0;
    numerator     = '0;
    denominator   = '0;
    hold_left     = 0;
    limit_writes  = 0;
    send_idle_pct = 10;
    recv_idle_pct = 79;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset limit of 10000: zeros, limit edges, reducible and coprime pairs
    send_fraction(0, 7);
    send_fraction(7, 0);
    send_fraction(0, 0);
    send_fraction(1, 1);
    send_fraction(10000, 10000);
    send_fraction(10001, 5);
    send_fraction(5, 10001);
    send_fraction(16383, 16383);
    send_fraction(10000, 1);
    send_fraction(1, 10000);
    send_fraction(12, 18);
    send_fraction(9973, 9967);
    send_fraction(8192, 4096);
    send_fraction(6561, 2187);
    send_fraction(9999, 3333);
    drain();

    write_limit(16383);
    send_fraction(16383, 16383);
    send_fraction(16383, 1);
    send_fraction(1, 16383);
    send_fraction(16382, 16383);
    send_fraction(10922, 16383);
    send_fraction(8191, 16382);
    drain();

    write_limit(1);
    send_fraction(1, 1);
    send_fraction(1, 2);
    send_fraction(2, 1);
    drain();

    // a limit of zero turns every fraction into an error
    write_limit(0);
    send_fraction(1, 1);
    send_fraction(0, 0);
    send_fraction(16383, 16383);
    drain();

    write_limit(value_t'($urandom_range(1, VALUE_TOP)));
    send_random(250);
    drain();

    send_idle_pct = 79;
    recv_idle_pct = 10;
    write_limit(10000);
    send_random(300);
    drain();
    write_limit(16383);
    send_random(200);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_limit(16383);
    hold_left = HOLD_CYCLES;
    send_random(350);
    drain();
    write_limit(100);
    send_random(200);
    drain();

    if (sb.pending.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, sb.pending.size());
      sb.mismatches++;
    end
    $display("Reduced %0d fractions under %0d limit settings; %0d results checked,",
             sb.fractions_taken, limit_writes, sb.results_seen);
    $display("%0d of them flagged as out of range, %0d mismatches",
             sb.errors_flagged, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+sv
sv/frg_pkg.sv
sv/frg_datapath.sv
sv/frg_controller.sv
sv/fraction_reducer_gcd_unit.sv
bench/testbench.sv
